FILE: hw/rtl/frame_free_list_allocator_assert.svh
// Assertion macros for the frame free-list allocator.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ffla_pkg.sv
// Shared types, constants and helpers for the frame free-list allocator.
// No dependencies.
`default_nettype none

package ffla_pkg;

  localparam int STACK_DEPTH = 4096;
  localparam int MAX_BATCH   = 64;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);

  localparam int ADDR_W  = 32;
  localparam int TOP_W   = 13;   // holds 0..STACK_DEPTH, matches free_count
  localparam int FS_W    = 17;
  localparam int BATCH_W = 7;
  localparam int MUL_W   = TOP_W + FS_W;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_REINIT  = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SHORT  = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE  = 2'd1;

  localparam logic [TOP_W-1:0] FRAME_COUNT_RST = 13'd4096;
  localparam logic [FS_W-1:0]  FRAME_SIZE_RST  = 17'd2048;

  typedef struct packed {
    logic [1:0]         func;
    logic [BATCH_W-1:0] batch_count;
    logic [ADDR_W-1:0]  frame_addr;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_addr;
    logic [1:0]        status;
    logic              last;
    logic [TOP_W-1:0]  free_count;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_RELEASE,
    S_FILL
  } state_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_DEC,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } alu_req_t;

  function automatic logic [TOP_W-1:0] eff_count(input logic [TOP_W-1:0] fc);
    return (fc > TOP_W'(STACK_DEPTH)) ? TOP_W'(STACK_DEPTH) : fc;
  endfunction

  function automatic logic [TOP_W-1:0] free_frames(input logic [TOP_W-1:0] n,
                                                   input logic [TOP_W-1:0] top);
    return (top >= n) ? '0 : n - top;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ffla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ffla_alu.sv
// Shared arithmetic unit: add, decrement and the release-limit multiply.
// Depends on ffla_pkg.
`default_nettype none

module ffla_alu
  import ffla_pkg::*;
(
  input  wire alu_req_t          req,
  output logic [ADDR_W-1:0]      y
);

  logic [MUL_W-1:0] prod;

  // frame count times frame size, narrow operands only
  assign prod = req.a[TOP_W-1:0] * req.b[FS_W-1:0];

  always_comb begin
    unique case (req.op)
      ALU_ADD: y = req.a + req.b;
      ALU_DEC: y = req.a - ADDR_W'(1);
      ALU_MUL: y = {{(ADDR_W-MUL_W){1'b0}}, prod};
      default: y = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/frame_free_list_allocator.sv
// Top level of the frame free-list allocator: sequencer, stack memory, shared ALU.
// Depends on ffla_pkg, ffla_ram, ffla_alu and frame_free_list_allocator_assert.svh.
`default_nettype none

`include "frame_free_list_allocator_assert.svh"

// A command is taken when start is high and busy is low. An allocate of n frames
// keeps busy through one decode state, then one stack read per frame; results
// come one per cycle, each in the cycle after its read, because the stack memory
// has a registered read port. A release does the frame_count * frame_size
// multiply in the shared ALU in the decode state, then the range check and the
// push. A reinitialize rewrites the whole stack, one entry per cycle, and reports
// once at the end. After reset the same fill runs with busy high; configuration
// writes are taken only while busy and start are both low.
// Results are single-cycle strobes on result_valid and cannot be held off, so
// the receiver must take each one.
module frame_free_list_allocator
  import ffla_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire cmd_t                 cmd,
  output logic                      result_valid,
  output result_t                   result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  state_t            state, state_next;
  cmd_t              cmd_q;
  logic [TOP_W-1:0]  top_index, top_index_next;
  logic [BATCH_W-1:0] batch_left, batch_left_next;
  logic [MUL_W-1:0]  limit, limit_next;
  logic [STACK_AW-1:0] fill_idx, fill_idx_next;
  logic [ADDR_W-1:0] fill_val, fill_val_next;
  logic              fill_report, fill_report_next;
  logic              res_valid, res_valid_next;
  logic              res_from_ram, res_from_ram_next;
  result_t           res, res_next;
  logic [TOP_W-1:0]  frame_count;
  logic [FS_W-1:0]   frame_size;

  alu_req_t          alu_req;
  logic [ADDR_W-1:0] alu_y;
  logic              ram_we, ram_re;
  logic [STACK_AW-1:0] ram_waddr, ram_raddr;
  logic [ADDR_W-1:0] ram_wdata, ram_rdata;

  logic [TOP_W-1:0]  eff_n, free_now;
  logic              alloc_short, alloc_go, fill_last, rel_reject;

  ffla_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ffla_alu u_alu (
    .req(alu_req),
    .y  (alu_y)
  );

  assign eff_n       = eff_count(frame_count);
  assign free_now    = free_frames(eff_n, top_index);
  assign alloc_short = (cmd_q.batch_count > BATCH_W'(MAX_BATCH)) ||
                       (TOP_W'(cmd_q.batch_count) > free_now);
  assign alloc_go    = (cmd_q.batch_count != '0) && !alloc_short;
  assign fill_last   = (fill_idx == STACK_AW'(STACK_DEPTH - 1));
  assign rel_reject  = (top_index == '0) ||
                       (cmd_q.frame_addr >= {{(ADDR_W-MUL_W){1'b0}}, limit});

  assign busy      = (state != S_IDLE);
  // register writes only between commands, never alongside a command transfer
  assign cfg_ready = !busy && !start;

  assign result_valid      = res_valid;
  assign result.alloc_addr = res_from_ram ? ram_rdata : '0;
  assign result.status     = res.status;
  assign result.last       = res.last;
  assign result.free_count = res.free_count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (cmd_q.func)
          FUNC_ALLOC:   state_next = alloc_go ? S_POP : S_IDLE;
          FUNC_RELEASE: state_next = S_RELEASE;
          FUNC_REINIT:  state_next = S_FILL;
          default:      state_next = S_IDLE;
        endcase
      end
      S_POP: begin
        if (batch_left == BATCH_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_RELEASE: state_next = S_IDLE;
      S_FILL: begin
        if (fill_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control and register next values
  always_comb begin
    alu_req           = '{op: ALU_ADD, a: '0, b: '0};
    ram_we            = 1'b0;
    ram_waddr         = fill_idx;
    ram_wdata         = fill_val;
    ram_re            = 1'b0;
    ram_raddr         = top_index[STACK_AW-1:0];
    top_index_next    = top_index;
    batch_left_next   = batch_left;
    limit_next        = limit;
    fill_idx_next     = fill_idx;
    fill_val_next     = fill_val;
    fill_report_next  = fill_report;
    res_valid_next    = 1'b0;
    res_from_ram_next = 1'b0;
    res_next          = '{alloc_addr: '0, status: STATUS_OK, last: 1'b1,
                          free_count: free_now};
    unique case (state)
      S_IDLE: ;
      S_DECODE: begin
        unique case (cmd_q.func)
          FUNC_ALLOC: begin
            batch_left_next = cmd_q.batch_count;
            if (!alloc_go) begin
              res_valid_next = 1'b1;
              res_next.status = (cmd_q.batch_count == '0) ? STATUS_OK : STATUS_SHORT;
            end
          end
          FUNC_RELEASE: begin
            alu_req    = '{op: ALU_MUL, a: ADDR_W'(eff_n), b: ADDR_W'(frame_size)};
            limit_next = alu_y[MUL_W-1:0];
          end
          FUNC_REINIT: begin
            fill_idx_next    = '0;
            fill_val_next    = '0;
            fill_report_next = 1'b1;
          end
          default: ;
        endcase
      end
      S_POP: begin
        ram_re            = 1'b1;
        alu_req           = '{op: ALU_ADD, a: ADDR_W'(top_index), b: ADDR_W'(1)};
        top_index_next    = alu_y[TOP_W-1:0];
        batch_left_next   = batch_left - BATCH_W'(1);
        res_valid_next    = 1'b1;
        res_from_ram_next = 1'b1;
        res_next.last       = (batch_left == BATCH_W'(1));
        res_next.free_count = free_frames(eff_n, alu_y[TOP_W-1:0]);
      end
      S_RELEASE: begin
        alu_req        = '{op: ALU_DEC, a: ADDR_W'(top_index), b: '0};
        res_valid_next = 1'b1;
        if (rel_reject) begin
          res_next.status = STATUS_REJECT;
        end else begin
          // push: decrement first, then store
          top_index_next      = alu_y[TOP_W-1:0];
          ram_we              = 1'b1;
          ram_waddr           = alu_y[STACK_AW-1:0];
          ram_wdata           = cmd_q.frame_addr;
          res_next.free_count = free_frames(eff_n, alu_y[TOP_W-1:0]);
        end
      end
      S_FILL: begin
        ram_we        = 1'b1;
        alu_req       = '{op: ALU_ADD, a: fill_val, b: ADDR_W'(frame_size)};
        fill_val_next = alu_y;
        fill_idx_next = fill_idx + STACK_AW'(1);
        if (fill_last) begin
          top_index_next      = '0;
          fill_report_next    = 1'b0;
          res_valid_next      = fill_report;
          res_next.free_count = eff_n;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      top_index    <= '0;
      fill_idx     <= '0;
      fill_val     <= '0;
      fill_report  <= 1'b0;
      res_valid    <= 1'b0;
      res_from_ram <= 1'b0;
      batch_left   <= '0;
      frame_count  <= FRAME_COUNT_RST;
      frame_size   <= FRAME_SIZE_RST;
    end else begin
      state        <= state_next;
      top_index    <= top_index_next;
      fill_idx     <= fill_idx_next;
      fill_val     <= fill_val_next;
      fill_report  <= fill_report_next;
      res_valid    <= res_valid_next;
      res_from_ram <= res_from_ram_next;
      batch_left   <= batch_left_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FRAME_COUNT: frame_count <= cfg_data[TOP_W-1:0];
          CFG_FRAME_SIZE:  frame_size  <= cfg_data[FS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res   <= res_next;
    limit <= limit_next;
    if (state == S_IDLE && start) begin
      cmd_q <= cmd;
    end
  end

  `FFLA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `FFLA_ASSERT_NXT(a_pop_result, state == S_POP,
                   result_valid && result.status == STATUS_OK,
                   "stack read without a matching result")
  `FFLA_ASSERT_NXT(a_fill_quiet, state == S_FILL && !fill_last, !result_valid,
                   "result during stack fill")
  `FFLA_ASSERT_IMP(a_top_range, 1'b1, top_index <= TOP_W'(STACK_DEPTH),
                   "stack index past depth")

endmodule

`default_nettype wire

FILE: tb/tb_frame_free_list_allocator.sv
// Self-checking testbench for frame_free_list_allocator: directed and random commands,
// random register settings, results checked against a behavioral stack model.
// Depends on ffla_pkg and the allocator RTL.
module tb_frame_free_list_allocator;
  import ffla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]           FUNC_NONE     = 2'd3;  // unused code, block ignores it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;  // index with no register behind it
  localparam int                   SETTLE_CYCLES = 8;
  localparam int                   WATCHDOG_MAX  = 20000; // must outlast a full reinit, which reports only at its end
  localparam int                   PHASE_CMDS    = 34;
  localparam int                   RAND_PHASES   = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  cmd_t                 cmd = '0;
  logic                 result_valid;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // allocator model state
  logic [ADDR_W-1:0] frame_mem [STACK_DEPTH];
  int unsigned       stack_top;
  logic [TOP_W-1:0]  fc_reg;
  logic [FS_W-1:0]   fs_reg;

  cmd_t    cmd_backlog [$];
  result_t due_results [$];
  int      mismatches = 0;
  bit      steady = 1'b0;

  frame_free_list_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned usable_frames();
    return (fc_reg > STACK_DEPTH) ? STACK_DEPTH : fc_reg;
  endfunction

  function automatic int unsigned frames_left();
    return (stack_top >= usable_frames()) ? 0 : usable_frames() - stack_top;
  endfunction

  function automatic logic [63:0] release_limit();
    return 64'(usable_frames()) * 64'(fs_reg);
  endfunction

  function automatic result_t make_result(input logic [ADDR_W-1:0] addr,
                                          input logic [1:0] st, input logic lst);
    result_t r;
    r.alloc_addr = addr;
    r.status     = st;
    r.last       = lst;
    r.free_count = TOP_W'(frames_left());
    return r;
  endfunction

  task automatic reload_stack();
    for (int i = 0; i < STACK_DEPTH; i++) frame_mem[i] = 32'(64'(i) * 64'(fs_reg));
    stack_top = 0;
  endtask

  // advance the model by one command and queue the results it owes
  task automatic stack_step(input cmd_t c);
    logic [ADDR_W-1:0] v;
    case (c.func)
      FUNC_ALLOC: begin
        if (c.batch_count == 0) begin
          due_results.push_back(make_result('0, STATUS_OK, 1'b1));
        end else if (c.batch_count > MAX_BATCH || c.batch_count > frames_left()) begin
          due_results.push_back(make_result('0, STATUS_SHORT, 1'b1));
        end else begin
          for (int i = 0; i < c.batch_count; i++) begin
            v = (stack_top < STACK_DEPTH) ? frame_mem[stack_top] : '0;
            stack_top++;
            due_results.push_back(make_result(v, STATUS_OK, i == c.batch_count - 1));
          end
        end
      end
      FUNC_RELEASE: begin
        if (stack_top == 0 || 64'(c.frame_addr) >= release_limit()) begin
          due_results.push_back(make_result('0, STATUS_REJECT, 1'b1));
        end else begin
          stack_top--;
          if (stack_top < STACK_DEPTH) frame_mem[stack_top] = c.frame_addr;
          due_results.push_back(make_result('0, STATUS_OK, 1'b1));
        end
      end
      FUNC_REINIT: begin
        reload_stack();
        due_results.push_back(make_result('0, STATUS_OK, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_cmd(input logic [1:0] f, input logic [BATCH_W-1:0] n,
                           input logic [ADDR_W-1:0] a);
    cmd_t c;
    c.func        = f;
    c.batch_count = n;
    c.frame_addr  = a;
    cmd_backlog.push_back(c);
  endtask

  // register write; bits above the register width are random
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] keep;
    keep = (idx == CFG_FRAME_COUNT) ? 32'h1FFF :
           (idx == CFG_FRAME_SIZE)  ? 32'h1FFFF : 32'h0;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ($urandom() & ~keep) | (value & keep);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FRAME_COUNT) fc_reg = cfg_data[TOP_W-1:0];
    else if (idx == CFG_FRAME_SIZE) fs_reg = cfg_data[FS_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // wait until the block has drained everything and is idle
  task automatic settle();
    while (cmd_backlog.size() != 0 || start || due_results.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) stack_step(cmd);
      if (!(start && busy)) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 34)) begin
          start <= 1'b1;
          cmd   <= cmd_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", result));
      end else begin
        want = due_results.pop_front();
        if (result.alloc_addr !== want.alloc_addr)
          report_mismatch($sformatf("alloc_addr got %h want %h",
                                    result.alloc_addr, want.alloc_addr));
        if (result.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", result.status, want.status));
        if (result.last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", result.last, want.last));
        if (result.free_count !== want.free_count)
          report_mismatch($sformatf("free_count got %0d want %0d",
                                    result.free_count, want.free_count));
      end
    end
  end

  // stall watchdog: any transfer on any channel resets it
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_MAX) begin
      @(posedge clk);
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [TOP_W-1:0]   fc_pick;
    logic [FS_W-1:0]    fs_pick;
    logic [63:0]        lim;
    logic [BATCH_W-1:0] n;
    logic [ADDR_W-1:0]  a;
    int                 counted;
    int                 r;

    fc_reg = FRAME_COUNT_RST;
    fs_reg = FRAME_SIZE_RST;
    reload_stack();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, 4096 frames of 2048 bytes
    @(negedge clk);
    queue_cmd(FUNC_RELEASE, 7'd0, 32'h10);          // stack full
    queue_cmd(FUNC_ALLOC, 7'd0, 32'h0);             // empty batch
    queue_cmd(FUNC_ALLOC, 7'd1, 32'h0);
    queue_cmd(FUNC_ALLOC, 7'd64, 32'h0);
    queue_cmd(FUNC_ALLOC, 7'd65, 32'h0);            // batch above max
    queue_cmd(FUNC_ALLOC, 7'd127, 32'hFFFF_FFFF);
    queue_cmd(FUNC_NONE, 7'd127, 32'hFFFF_FFFF);    // ignored
    queue_cmd(FUNC_RELEASE, 7'd0, 32'd8388607);     // last offset in range
    queue_cmd(FUNC_RELEASE, 7'd0, 32'd8388608);     // first offset out of range
    queue_cmd(FUNC_RELEASE, 7'd127, 32'hFFFF_FFFF);
    queue_cmd(FUNC_RELEASE, 7'd0, 32'h0000_0A5A);
    queue_cmd(FUNC_ALLOC, 7'd2, 32'h0);             // pops the two released offsets
    queue_cmd(FUNC_REINIT, 7'd0, 32'h0);
    settle();
    write_reg(CFG_SPARE, $urandom());
    write_reg(CFG_FRAME_COUNT, 32'd5);
    write_reg(CFG_FRAME_SIZE, 32'd1);
    @(negedge clk);
    queue_cmd(FUNC_ALLOC, 7'd5, 32'h0);
    queue_cmd(FUNC_ALLOC, 7'd1, 32'h0);             // nothing left
    queue_cmd(FUNC_RELEASE, 7'd0, 32'd4);
    queue_cmd(FUNC_RELEASE, 7'd0, 32'd5);
    queue_cmd(FUNC_ALLOC, 7'd1, 32'h0);
    settle();
    write_reg(CFG_FRAME_COUNT, 32'd2);              // now below the stack top
    @(negedge clk);
    queue_cmd(FUNC_ALLOC, 7'd1, 32'h0);
    queue_cmd(FUNC_RELEASE, 7'd0, 32'd1);
    settle();
    write_reg(CFG_FRAME_COUNT, 32'd0);
    @(negedge clk);
    queue_cmd(FUNC_RELEASE, 7'd0, 32'd0);
    queue_cmd(FUNC_ALLOC, 7'd1, 32'h0);
    settle();
    write_reg(CFG_FRAME_COUNT, 32'd8191);           // clamps to stack depth
    write_reg(CFG_FRAME_SIZE, 32'd0);
    @(negedge clk);
    queue_cmd(FUNC_RELEASE, 7'd0, 32'd0);
    settle();
    write_reg(CFG_FRAME_SIZE, 32'd131071);
    @(negedge clk);
    queue_cmd(FUNC_ALLOC, 7'd64, 32'h0);
    queue_cmd(FUNC_RELEASE, 7'd0, 32'd536866815);   // 4096 * 131071 - 1

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      case ($urandom_range(0, 5))
        0: fc_pick = 13'd1;
        1: fc_pick = 13'($urandom_range(2, 80));
        2: fc_pick = 13'd4096;
        3: fc_pick = 13'd8191;
        4: fc_pick = 13'($urandom_range(1, 8191));
        default: fc_pick = 13'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 5))
        0: fs_pick = 17'd1;
        1: fs_pick = 17'd2048;
        2: fs_pick = 17'd65536;
        3: fs_pick = 17'd131071;
        4: fs_pick = 17'($urandom_range(1, 131071));
        default: fs_pick = 17'($urandom_range(0, 15));
      endcase
      write_reg(CFG_FRAME_COUNT, 32'(fc_pick));
      write_reg(CFG_FRAME_SIZE, 32'(fs_pick));
      steady = (p == RAND_PHASES / 2);
      lim = release_limit();
      @(negedge clk);
      counted = 0;
      while (counted < PHASE_CMDS) begin
        r = $urandom_range(0, 99);
        if (r < 48) begin
          case ($urandom_range(0, 19))
            0:       n = 7'd0;
            1:       n = 7'($urandom_range(65, 127));
            2, 3:    n = 7'($urandom_range(1, 64));
            default: n = 7'($urandom_range(1, 16));
          endcase
          queue_cmd(FUNC_ALLOC, n, $urandom());
          counted++;
        end else if (r < 87) begin
          if (lim != 0 && $urandom_range(0, 9) != 0) a = $urandom_range(0, 32'(lim - 1));
          else a = $urandom();
          queue_cmd(FUNC_RELEASE, 7'($urandom()), a);
          counted++;
        end else if (r < 89) begin
          queue_cmd(FUNC_REINIT, 7'($urandom()), $urandom());
          counted++;
        end else begin
          queue_cmd(FUNC_NONE, 7'($urandom()), $urandom());
        end
      end
    end

    settle();
    steady = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
